/* rtl/core/lru_block_cache_top_defines.svh */
// Assertion macros shared by the cache checker.
`ifndef LRU_BLOCK_CACHE_TOP_DEFINES_SVH
`define LRU_BLOCK_CACHE_TOP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LRUB_ASSERT_NOW(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("cache check failed");

// The consequent must hold in the cycle after the antecedent.
`define LRUB_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("cache check failed");

`endif

/* rtl/core/lrub_pkg.sv */
// Types and constants shared by the block cache modules.
`default_nettype none
package lrub_pkg;

  localparam int SLOT_W = 6;
  localparam int CNT_W = 7;

  localparam logic [1:0] OP_SEARCH = 2'd0;
  localparam logic [1:0] OP_PUSH = 2'd1;
  localparam logic [1:0] OP_UPDATE = 2'd2;

  localparam logic [1:0] ST_MISS = 2'd0;
  localparam logic [1:0] ST_HIT = 2'd1;
  localparam logic [1:0] ST_PUSHED = 2'd2;

  typedef struct packed {
    logic [1:0]  operation;
    logic [31:0] block_addr;
    logic [3:0]  word_index;
    logic [63:0] data_word;
    logic [7:0]  byte_enable;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [3:0]  word_index_res;
    logic [63:0] data_word_res;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic              hit;
    logic [SLOT_W-1:0] hit_idx;
    logic [SLOT_W-1:0] hit_rank;
    logic              upd;
    logic [SLOT_W-1:0] upd_idx;
    logic [SLOT_W-1:0] lru_idx;
    logic [SLOT_W-1:0] lru_rank;
    logic              ps_hit;
  } carry_t;

  typedef struct packed {
    logic              en;
    logic [SLOT_W-1:0] slot;
    logic [SLOT_W-1:0] old_rank;
    logic [CNT_W-1:0]  filled;
    logic              tag_we;
    logic [31:0]       tag;
  } commit_t;

endpackage
`default_nettype wire

/* rtl/core/lru_block_cache_top.sv */
// Top level of the fully associative block cache with least recent replacement.
//
//   Channel   Handshake            Payload
//   input     in_valid/in_ready    in_data (in_item_t)
//   output    out_valid/out_ready  out_data (out_item_t)
//   config    cfg_we               cfg_wdata (capacity)
//
// One item is worked at a time; in_ready is high only while idle.
// A lookup walks the chain of ENTRIES slot cells, one cell a cycle, then decides.
// A miss, push or rejected item goes from S_DECIDE to S_EMIT; an update also visits S_RMW.
// A hit streams BLOCK_WORDS words via the data memory port; S_READ reads, S_LOAD sends.
// A stalled output holds the last result; reset is synchronous and needs no clearing pass.
`default_nettype none
module lru_block_cache_top #(
  parameter int ENTRIES = 16,
  parameter int BLOCK_WORDS = 16,
  parameter int ADDR_BITS = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  lrub_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output lrub_pkg::out_item_t out_data,
  input  logic                cfg_we,
  input  logic [4:0]          cfg_wdata
);
  import lrub_pkg::*;

  localparam int TW = (ADDR_BITS < 32) ? ADDR_BITS : 32;
  localparam int SW = $clog2(ENTRIES);
  localparam int WW = (BLOCK_WORDS > 1) ? $clog2(BLOCK_WORDS) : 1;
  localparam int AW = SW + WW;
  localparam int CW = $clog2(ENTRIES + 1);
  localparam int KW = (CW > 5) ? CW : 5;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;
  localparam logic [2:0] S_DECIDE = 3'd2;
  localparam logic [2:0] S_RMW = 3'd3;
  localparam logic [2:0] S_READ = 3'd4;
  localparam logic [2:0] S_LOAD = 3'd5;
  localparam logic [2:0] S_EMIT = 3'd6;

  logic [2:0]    state, state_next;
  in_item_t      req;
  logic [SW-1:0] cnt;
  logic [WW-1:0] word, word_next;
  logic [SW-1:0] slot, slot_next;
  logic [1:0]    res_status, res_status_next;
  logic [4:0]    entries_in_use;
  logic [CW-1:0] filled_count, filled_count_next;
  logic [SW-1:0] push_slot, push_slot_next;

  logic [63:0]   mem [ENTRIES * (2 ** WW)];
  logic [63:0]   mem_rdata;
  logic          mem_we, mem_re;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [63:0]   mem_wdata;

  logic [TW-1:0] key;
  logic          invalid;
  logic          wi_ok;
  logic [KW-1:0] cap;
  logic          room;
  logic          out_free;
  logic          load_word, load_res;
  logic [63:0]   mask;
  carry_t        carry_q [ENTRIES];
  carry_t        fin;
  commit_t       commit;

  assign key = req.block_addr[TW-1:0];
  assign invalid = (ADDR_BITS <= 32) && (&key);
  assign wi_ok = 32'(req.word_index) < 32'(BLOCK_WORDS);
  assign fin = carry_q[ENTRIES-1];
  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == S_IDLE);

  always_comb begin
    if (entries_in_use == 5'd0) begin
      cap = KW'(1);
    end else if (KW'(entries_in_use) > KW'(ENTRIES)) begin
      cap = KW'(ENTRIES);
    end else begin
      cap = KW'(entries_in_use);
    end
  end
  assign room = KW'(filled_count) < cap;

  always_comb begin
    for (int b = 0; b < 8; b++) begin
      mask[8*b +: 8] = {8{req.byte_enable[b]}};
    end
  end

  genvar k;
  generate
    for (k = 0; k < ENTRIES; k++) begin : g_cell
      carry_t cin;
      if (k == 0) begin : g_first
        assign cin = '0;
      end else begin : g_rest
        assign cin = carry_q[k-1];
      end
      lrub_cell #(
        .ENTRIES (ENTRIES),
        .TAG_BITS(TW),
        .IDX     (k)
      ) u_cell (
        .clk      (clk),
        .rst      (rst),
        .key      (key),
        .filled   (CNT_W'(filled_count)),
        .push_slot(SLOT_W'(push_slot)),
        .carry_in (cin),
        .commit   (commit),
        .carry_out(carry_q[k])
      );
    end
  endgenerate

  always_comb begin
    state_next = state;
    word_next = word;
    slot_next = slot;
    res_status_next = res_status;
    filled_count_next = filled_count;
    push_slot_next = push_slot;
    commit = '0;
    commit.filled = CNT_W'(filled_count);
    commit.tag = 32'(key);
    mem_we = 1'b0;
    mem_re = 1'b0;
    mem_waddr = {slot, word};
    mem_raddr = {slot, word};
    mem_wdata = req.data_word;
    load_word = 1'b0;
    load_res = 1'b0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        if (cnt == SW'(ENTRIES - 1)) begin
          state_next = S_DECIDE;
        end
      end
      S_DECIDE: begin
        res_status_next = ST_MISS;
        state_next = S_EMIT;
        case (req.operation)
          OP_SEARCH: begin
            if (!invalid && fin.hit) begin
              commit.en = 1'b1;
              commit.slot = fin.hit_idx;
              commit.old_rank = fin.hit_rank;
              slot_next = SW'(fin.hit_idx);
              word_next = '0;
              state_next = S_READ;
            end
          end
          OP_PUSH: begin
            if (!invalid) begin
              if (req.word_index == 4'd0) begin
                commit.en = 1'b1;
                commit.tag_we = 1'b1;
                if (room) begin
                  commit.slot = SLOT_W'(filled_count);
                  commit.old_rank = SLOT_W'(filled_count);
                  commit.filled = CNT_W'(filled_count) + CNT_W'(1);
                  filled_count_next = filled_count + CW'(1);
                end else begin
                  commit.slot = fin.lru_idx;
                  commit.old_rank = fin.lru_rank;
                end
                push_slot_next = SW'(commit.slot);
                mem_we = 1'b1;
                mem_waddr = {SW'(commit.slot), WW'(0)};
                res_status_next = ST_PUSHED;
              end else if (fin.ps_hit && wi_ok) begin
                mem_we = 1'b1;
                mem_waddr = {push_slot, WW'(req.word_index)};
                res_status_next = ST_PUSHED;
              end
            end
          end
          OP_UPDATE: begin
            if (!invalid && wi_ok && fin.upd) begin
              slot_next = SW'(fin.upd_idx);
              word_next = WW'(req.word_index);
              mem_re = 1'b1;
              mem_raddr = {SW'(fin.upd_idx), WW'(req.word_index)};
              state_next = S_RMW;
            end
          end
          default: begin
            res_status_next = ST_MISS;
          end
        endcase
      end
      S_RMW: begin
        mem_we = 1'b1;
        mem_wdata = (mem_rdata & ~mask) | (req.data_word & mask);
        res_status_next = ST_HIT;
        state_next = S_EMIT;
      end
      S_READ: begin
        mem_re = 1'b1;
        state_next = S_LOAD;
      end
      S_LOAD: begin
        if (out_free) begin
          load_word = 1'b1;
          if (32'(word) == 32'(BLOCK_WORDS - 1)) begin
            state_next = S_IDLE;
          end else begin
            word_next = word + WW'(1);
            state_next = S_READ;
          end
        end
      end
      S_EMIT: begin
        if (out_free) begin
          load_res = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt <= '0;
      filled_count <= '0;
      push_slot <= '0;
      entries_in_use <= 5'd16;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      filled_count <= filled_count_next;
      push_slot <= push_slot_next;
      if (state == S_SCAN) begin
        cnt <= cnt + SW'(1);
      end else begin
        cnt <= '0;
      end
      if (cfg_we) begin
        entries_in_use <= cfg_wdata;
      end
      if (load_word || load_res) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    word <= word_next;
    slot <= slot_next;
    res_status <= res_status_next;
    if (in_valid && in_ready) begin
      req <= in_data;
    end
    if (load_word) begin
      out_data.status <= ST_HIT;
      out_data.word_index_res <= 4'(word);
      out_data.data_word_res <= mem_rdata;
      out_data.last <= (32'(word) == 32'(BLOCK_WORDS - 1));
    end else if (load_res) begin
      out_data.status <= res_status;
      out_data.word_index_res <= 4'd0;
      out_data.data_word_res <= 64'd0;
      out_data.last <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rdata <= mem[mem_raddr];
    end
  end

endmodule
`default_nettype wire

/* rtl/core/lrub_cell.sv */
// One cache slot: tag, recency rank and a registered stage of the search chain.
`default_nettype none
module lrub_cell #(
  parameter int ENTRIES = 16,
  parameter int TAG_BITS = 32,
  parameter int IDX = 0
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic [TAG_BITS-1:0]   key,
  input  logic [lrub_pkg::CNT_W-1:0]  filled,
  input  logic [lrub_pkg::SLOT_W-1:0] push_slot,
  input  lrub_pkg::carry_t      carry_in,
  input  lrub_pkg::commit_t     commit,
  output lrub_pkg::carry_t      carry_out
);
  import lrub_pkg::*;

  localparam int RW = $clog2(ENTRIES);

  logic [RW-1:0]       rank;
  logic [TAG_BITS-1:0] tag;
  logic                valid;
  logic                match;
  logic                valid_after;
  logic [SLOT_W-1:0]   my_rank;
  logic [SLOT_W-1:0]   my_idx;
  logic [SLOT_W-1:0]   lru_target;
  carry_t              c;

  assign my_rank = SLOT_W'(rank);
  assign my_idx = SLOT_W'(IDX);
  assign valid = CNT_W'(IDX) < filled;
  assign valid_after = CNT_W'(IDX) < commit.filled;
  assign match = valid && (tag == key);
  assign lru_target = SLOT_W'(filled - CNT_W'(1));

  always_comb begin
    c = carry_in;
    if (match && (!carry_in.hit || my_rank < carry_in.hit_rank)) begin
      c.hit = 1'b1;
      c.hit_idx = my_idx;
      c.hit_rank = my_rank;
    end
    if (match && !carry_in.upd) begin
      c.upd = 1'b1;
      c.upd_idx = my_idx;
    end
    if (IDX == 0 || (valid && my_rank == lru_target)) begin
      c.lru_idx = my_idx;
      c.lru_rank = my_rank;
    end
    if (match && my_idx == push_slot) begin
      c.ps_hit = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    carry_out <= c;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rank <= '0;
    end else if (commit.en) begin
      if (my_idx == commit.slot) begin
        rank <= '0;
      end else if (valid_after && my_rank < commit.old_rank) begin
        rank <= rank + RW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (commit.en && commit.tag_we && my_idx == commit.slot) begin
      tag <= commit.tag[TAG_BITS-1:0];
    end
  end

endmodule
`default_nettype wire

/* rtl/core/lrub_checker.sv */
// Port level checks for the block cache and their binding to the top level.
`include "lru_block_cache_top_defines.svh"
`default_nettype none
module lrub_checker (
  input wire logic                clk,
  input wire logic                rst,
  input wire logic                in_valid,
  input wire logic                in_ready,
  input wire logic                out_valid,
  input wire logic                out_ready,
  input wire lrub_pkg::out_item_t out_data
);
  import lrub_pkg::*;

  `LRUB_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(out_data))
  `LRUB_ASSERT_NOW(a_not_hit_last, clk, rst, out_valid && out_data.status != ST_HIT, out_data.last)
  `LRUB_ASSERT_NOW(a_push_zero, clk, rst, out_valid && out_data.status == ST_PUSHED, out_data.word_index_res == 4'd0 && out_data.data_word_res == 64'd0)
  `LRUB_ASSERT_NOW(a_reset_quiet, clk, rst, $past(rst), !out_valid && in_ready)

endmodule

bind lru_block_cache_top lrub_checker u_lrub_checker (.*);
`default_nettype wire
